FILE: rtl/ffa_pkg.sv
package ffa_pkg;

    localparam int ADDR_W  = 16;
    localparam int LEN_W   = 17;
    localparam int SIZE_W  = 17;
    localparam int ALIGN_W = 13;
    localparam int STAT_W  = 2;

    localparam logic [LEN_W-1:0] MIN_ALLOC = 17'd16;
    localparam logic [LEN_W-1:0] ARENA_MIN = 17'd64;
    localparam logic [LEN_W-1:0] ARENA_MAX = 17'd65536;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADADR = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic [SIZE_W-1:0]  req_size;
        logic [ALIGN_W-1:0] align;
        logic [ADDR_W-1:0]  block_addr;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] result_addr;
        logic [LEN_W-1:0]  used_bytes_out;
    } t_out_item;

    // normalized request handed from front to back
    typedef struct packed {
        logic               cmd;
        logic [SIZE_W-1:0]  size;
        logic [ALIGN_W-1:0] align;
        logic [ADDR_W-1:0]  addr;
    } t_job;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } t_seg;

    typedef struct packed {
        logic [ADDR_W-1:0] user;
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } t_blk;

endpackage

FILE: rtl/first_fit_free_list_allocator.sv
// channel   direction  handshake                      payload
// request   in         push / full                    i_in_item  (t_in_item)
// result    out        empty / pop                    o_out_item (t_out_item)
// config    in         i_cfg_valid / o_cfg_ready      i_cfg_data (arena size)
//
// one request at a time; an allocate scans the slots, then tries each segment in turn
// through the bit-serial remainder unit and moves entries when one is used up; a free
// looks up the block, passes the segments before it, moves entries and merges neighbours
// the segment memory has one read port and one write port
// after reset, and after each arena write, the init state rebuilds the table
// two-entry queues on both sides; a held result does not stop the next request queueing
module first_fit_free_list_allocator #(
    parameter int MAX_BLOCKS   = 16,
    parameter int HEADER_BYTES = 16,
    parameter int SPLIT_MIN    = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  ffa_pkg::t_in_item         i_in_item,
    output logic                      empty,
    input  logic                      pop,
    output ffa_pkg::t_out_item        o_out_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [ffa_pkg::LEN_W-1:0] i_cfg_data
);

    ffa_pkg::t_job      w_job;
    logic               w_job_empty;
    logic               w_job_pop;
    logic               w_out_full;
    logic               w_out_push;
    ffa_pkg::t_out_item w_out_item;

    // front: normalize and queue requests
    ffa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_in_item),
        .o_full  (full),
        .i_pop   (w_job_pop),
        .o_job   (w_job),
        .o_empty (w_job_empty)
    );

    // back: table walk, split, merge
    ffa_back #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .SPLIT_MIN    (SPLIT_MIN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_job_valid (!w_job_empty),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .i_out_full  (w_out_full),
        .o_out_push  (w_out_push),
        .o_out_item  (w_out_item)
    );

    // result queue
    ffa_fifo #(
        .WIDTH ($bits(ffa_pkg::t_out_item))
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_item),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty)
    );

    // a result beat never hits a full queue
    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_push |-> !w_out_full)
        else $error("result pushed into full queue");

    // an arena write starts the rebuild, so the port is busy next cycle
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> !o_cfg_ready)
        else $error("config port ready during rebuild");

    // used bytes never exceed the largest arena
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_item.used_bytes_out <= ffa_pkg::ARENA_MAX))
        else $error("used bytes out of range");

endmodule

FILE: rtl/ffa_fifo.sv
module ffa_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    // two-entry queue
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign o_data    = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wp <= ~r_wp;
            end
            if (w_do_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_do_push && w_do_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: rtl/ffa_front.sv
module ffa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ffa_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_pop,
    output ffa_pkg::t_job     o_job,
    output logic              o_empty
);

    ffa_pkg::t_job w_job;

    // raise small sizes, treat zero alignment as one
    always_comb begin
        w_job.cmd   = i_item.cmd;
        w_job.size  = (i_item.req_size < ffa_pkg::MIN_ALLOC) ? ffa_pkg::MIN_ALLOC
                                                              : i_item.req_size;
        w_job.align = (i_item.align == '0) ? ffa_pkg::ALIGN_W'(1) : i_item.align;
        w_job.addr  = i_item.block_addr;
    end

    ffa_fifo #(
        .WIDTH ($bits(ffa_pkg::t_job))
    ) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_job),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_job),
        .o_empty (o_empty)
    );

endmodule

FILE: rtl/ffa_back.sv
module ffa_back #(
    parameter int MAX_BLOCKS   = 16,
    parameter int HEADER_BYTES = 16,
    parameter int SPLIT_MIN    = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffa_pkg::LEN_W-1:0]      i_cfg_data,
    input  logic                           i_job_valid,
    input  ffa_pkg::t_job                  i_job,
    output logic                           o_job_pop,
    input  logic                           i_out_full,
    output logic                           o_out_push,
    output ffa_pkg::t_out_item             o_out_item
);

    localparam int SEG_DEPTH = MAX_BLOCKS + 1;
    localparam int SIW       = $clog2(SEG_DEPTH);
    localparam int CW        = $clog2(SEG_DEPTH + 1);
    localparam int BW        = $clog2(MAX_BLOCKS);
    localparam int AW        = ffa_pkg::ADDR_W;
    localparam int LW        = ffa_pkg::LEN_W;
    localparam int XW        = AW + 1;
    localparam int DW        = ffa_pkg::ALIGN_W;
    localparam int PW        = DW + 1;
    localparam int NW        = LW + 1;
    localparam int BITW      = $clog2(XW);

    localparam logic [4:0] S_INIT  = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_SLOT  = 5'd2;
    localparam logic [4:0] S_SEG   = 5'd3;
    localparam logic [4:0] S_SEGW  = 5'd4;
    localparam logic [4:0] S_MOD   = 5'd5;
    localparam logic [4:0] S_FIT   = 5'd6;
    localparam logic [4:0] S_SHRD  = 5'd7;
    localparam logic [4:0] S_SHWR  = 5'd8;
    localparam logic [4:0] S_FRD   = 5'd9;
    localparam logic [4:0] S_FCHK  = 5'd10;
    localparam logic [4:0] S_POS   = 5'd11;
    localparam logic [4:0] S_POSW  = 5'd12;
    localparam logic [4:0] S_UPRD  = 5'd13;
    localparam logic [4:0] S_UPWR  = 5'd14;
    localparam logic [4:0] S_PUT   = 5'd15;
    localparam logic [4:0] S_NX    = 5'd16;
    localparam logic [4:0] S_NXW   = 5'd17;
    localparam logic [4:0] S_PV    = 5'd18;
    localparam logic [4:0] S_PVW   = 5'd19;
    localparam logic [4:0] S_FDONE = 5'd20;
    localparam logic [4:0] S_RESP  = 5'd21;

    logic [4:0]                  r_state, n_state;
    logic [4:0]                  r_ret, n_ret;
    logic [LW-1:0]               r_arena, n_arena;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [MAX_BLOCKS-1:0]       r_valid, n_valid;
    logic [LW-1:0]               r_used, n_used;
    ffa_pkg::t_job               r_job, n_job;
    logic [BW-1:0]               r_slot, n_slot;
    logic [BW-1:0]               r_b, n_b;
    logic [CW-1:0]               r_i, n_i;
    logic [CW-1:0]               r_k, n_k;
    logic [AW-1:0]               r_s, n_s;
    logic [LW-1:0]               r_len, n_len;
    logic [LW-1:0]               r_blen, n_blen;
    logic [XW-1:0]               r_x, n_x;
    logic [DW-1:0]               r_rem, n_rem;
    logic [BITW-1:0]             r_bit, n_bit;
    logic [ffa_pkg::STAT_W-1:0]  r_status, n_status;
    logic [AW-1:0]               r_res, n_res;

    ffa_pkg::t_seg               r_seg_mem [SEG_DEPTH];
    ffa_pkg::t_seg               r_seg_rd;
    logic [SIW-1:0]              w_seg_ra, w_seg_wa;
    logic                        w_seg_we;
    ffa_pkg::t_seg               w_seg_wd;

    ffa_pkg::t_blk               r_blk_mem [MAX_BLOCKS];
    ffa_pkg::t_blk               r_blk_rd;
    logic                        w_blk_we;
    ffa_pkg::t_blk               w_blk_wd;

    logic [PW:0]                 w_rem_sh;
    logic [PW-1:0]               w_pad;
    logic [NW-1:0]               w_need;
    logic [NW-1:0]               w_left;
    logic [LW-1:0]               w_sum;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_push  = (r_state == S_RESP);
    assign o_out_item  = '{status: r_status, result_addr: r_res, used_bytes_out: r_used};

    // padding and size of the candidate block
    always_comb begin
        w_pad  = PW'(HEADER_BYTES) + ((r_rem == '0) ? PW'(0)
                                     : (PW'(r_job.align) - PW'(r_rem)));
        w_need = NW'(r_job.size) + NW'(w_pad);
        w_left = NW'(r_len) - w_need;
        w_rem_sh = {1'b0, r_rem, r_x[XW-1]};
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_arena  = r_arena;
        n_cnt    = r_cnt;
        n_valid  = r_valid;
        n_used   = r_used;
        n_job    = r_job;
        n_slot   = r_slot;
        n_b      = r_b;
        n_i      = r_i;
        n_k      = r_k;
        n_s      = r_s;
        n_len    = r_len;
        n_blen   = r_blen;
        n_x      = r_x;
        n_rem    = r_rem;
        n_bit    = r_bit;
        n_status = r_status;
        n_res    = r_res;
        o_job_pop = 1'b0;
        w_seg_ra = '0;
        w_seg_wa = '0;
        w_seg_we = 1'b0;
        w_seg_wd = '0;
        w_blk_we = 1'b0;
        w_blk_wd = '0;
        w_sum    = '0;
        case (r_state)
            S_INIT: begin
                w_seg_we = 1'b1;
                w_seg_wa = '0;
                w_seg_wd = '{start: '0, len: r_arena};
                n_cnt    = CW'(1);
                n_used   = '0;
                n_valid  = '0;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg_valid) begin
                    if (i_cfg_data < ffa_pkg::ARENA_MIN) begin
                        n_arena = ffa_pkg::ARENA_MIN;
                    end else if (i_cfg_data > ffa_pkg::ARENA_MAX) begin
                        n_arena = ffa_pkg::ARENA_MAX;
                    end else begin
                        n_arena = i_cfg_data;
                    end
                    n_state = S_INIT;
                end else if (i_job_valid && !i_out_full) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_status  = ffa_pkg::ST_OK;
                    n_res     = '0;
                    n_b       = '0;
                    n_state   = (i_job.cmd == ffa_pkg::CMD_ALLOC) ? S_SLOT : S_FRD;
                end
            end
            S_SLOT: begin
                if (!r_valid[r_b]) begin
                    n_slot  = r_b;
                    n_i     = '0;
                    n_state = S_SEG;
                end else if (r_b == BW'(MAX_BLOCKS - 1)) begin
                    n_status = ffa_pkg::ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    n_b = r_b + BW'(1);
                end
            end
            S_SEG: begin
                if (r_i == r_cnt) begin
                    n_status = ffa_pkg::ST_NOFIT;
                    n_state  = S_RESP;
                end else begin
                    w_seg_ra = r_i[SIW-1:0];
                    n_state  = S_SEGW;
                end
            end
            S_SEGW: begin
                n_s     = r_seg_rd.start;
                n_len   = r_seg_rd.len;
                n_x     = XW'(r_seg_rd.start) + XW'(HEADER_BYTES);
                n_rem   = '0;
                n_bit   = '0;
                n_state = S_MOD;
            end
            S_MOD: begin
                // restoring remainder, one bit per cycle
                if (w_rem_sh >= (PW+1)'(r_job.align)) begin
                    n_rem = DW'(w_rem_sh - (PW+1)'(r_job.align));
                end else begin
                    n_rem = DW'(w_rem_sh);
                end
                n_x   = {r_x[XW-2:0], 1'b0};
                n_bit = r_bit + BITW'(1);
                if (r_bit == BITW'(XW - 1)) begin
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                if (NW'(r_len) >= w_need) begin
                    if (w_left > NW'(SPLIT_MIN)) begin
                        w_seg_we = 1'b1;
                        w_seg_wa = r_i[SIW-1:0];
                        w_seg_wd = '{start: AW'(NW'(r_s) + w_need), len: LW'(w_left)};
                        n_blen   = LW'(w_need);
                        n_state  = S_RESP;
                    end else begin
                        n_blen  = r_len;
                        n_k     = r_i;
                        n_ret   = S_RESP;
                        n_state = S_SHRD;
                    end
                    w_blk_we = 1'b1;
                    w_blk_wd = '{user: r_s + AW'(w_pad), start: r_s, len: n_blen};
                    n_valid[r_slot] = 1'b1;
                    n_used = r_used + n_blen;
                    n_res  = r_s + AW'(w_pad);
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_SEG;
                end
            end
            S_SHRD: begin
                // close the gap at entry k
                if ((r_k + CW'(1)) < r_cnt) begin
                    w_seg_ra = SIW'(r_k + CW'(1));
                    n_state  = S_SHWR;
                end else begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = r_ret;
                end
            end
            S_SHWR: begin
                w_seg_we = 1'b1;
                w_seg_wa = r_k[SIW-1:0];
                w_seg_wd = r_seg_rd;
                n_k      = r_k + CW'(1);
                n_state  = S_SHRD;
            end
            S_FRD: begin
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (r_valid[r_b] && (r_blk_rd.user == r_job.addr)) begin
                    n_s    = r_blk_rd.start;
                    n_len  = r_blk_rd.len;
                    n_blen = r_blk_rd.len;
                    n_slot = r_b;
                    if (r_cnt >= CW'(SEG_DEPTH)) begin
                        n_status = ffa_pkg::ST_BADADR;
                        n_state  = S_RESP;
                    end else begin
                        n_i     = '0;
                        n_state = S_POS;
                    end
                end else if (r_b == BW'(MAX_BLOCKS - 1)) begin
                    n_status = ffa_pkg::ST_BADADR;
                    n_state  = S_RESP;
                end else begin
                    n_b     = r_b + BW'(1);
                    n_state = S_FRD;
                end
            end
            S_POS: begin
                if (r_i == r_cnt) begin
                    n_k     = r_cnt;
                    n_state = S_UPRD;
                end else begin
                    w_seg_ra = r_i[SIW-1:0];
                    n_state  = S_POSW;
                end
            end
            S_POSW: begin
                if (r_seg_rd.start > r_s) begin
                    n_k     = r_cnt;
                    n_state = S_UPRD;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_POS;
                end
            end
            S_UPRD: begin
                // open a gap at entry i
                if (r_k > r_i) begin
                    w_seg_ra = SIW'(r_k - CW'(1));
                    n_state  = S_UPWR;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_UPWR: begin
                w_seg_we = 1'b1;
                w_seg_wa = r_k[SIW-1:0];
                w_seg_wd = r_seg_rd;
                n_k      = r_k - CW'(1);
                n_state  = S_UPRD;
            end
            S_PUT: begin
                w_seg_we = 1'b1;
                w_seg_wa = r_i[SIW-1:0];
                w_seg_wd = '{start: r_s, len: r_len};
                n_cnt    = r_cnt + CW'(1);
                n_state  = S_NX;
            end
            S_NX: begin
                if ((r_i + CW'(1)) < r_cnt) begin
                    w_seg_ra = SIW'(r_i + CW'(1));
                    n_state  = S_NXW;
                end else begin
                    n_state = S_PV;
                end
            end
            S_NXW: begin
                if ((LW'(r_s) + r_len) == LW'(r_seg_rd.start)) begin
                    w_sum    = r_len + r_seg_rd.len;
                    n_len    = w_sum;
                    w_seg_we = 1'b1;
                    w_seg_wa = r_i[SIW-1:0];
                    w_seg_wd = '{start: r_s, len: w_sum};
                    n_k      = r_i + CW'(1);
                    n_ret    = S_PV;
                    n_state  = S_SHRD;
                end else begin
                    n_state = S_PV;
                end
            end
            S_PV: begin
                if (r_i != '0) begin
                    w_seg_ra = SIW'(r_i - CW'(1));
                    n_state  = S_PVW;
                end else begin
                    n_state = S_FDONE;
                end
            end
            S_PVW: begin
                if ((LW'(r_seg_rd.start) + r_seg_rd.len) == LW'(r_s)) begin
                    w_sum    = r_seg_rd.len + r_len;
                    w_seg_we = 1'b1;
                    w_seg_wa = SIW'(r_i - CW'(1));
                    w_seg_wd = '{start: r_seg_rd.start, len: w_sum};
                    n_k      = r_i;
                    n_ret    = S_FDONE;
                    n_state  = S_SHRD;
                end else begin
                    n_state = S_FDONE;
                end
            end
            S_FDONE: begin
                n_valid[r_slot] = 1'b0;
                n_used   = (r_used >= r_blen) ? (r_used - r_blen) : '0;
                n_status = ffa_pkg::ST_OK;
                n_state  = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ret   <= S_RESP;
            r_arena <= ffa_pkg::ARENA_MAX;
            r_cnt   <= CW'(1);
            r_valid <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_arena <= n_arena;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_slot   <= n_slot;
        r_b      <= n_b;
        r_i      <= n_i;
        r_k      <= n_k;
        r_s      <= n_s;
        r_len    <= n_len;
        r_blen   <= n_blen;
        r_x      <= n_x;
        r_rem    <= n_rem;
        r_bit    <= n_bit;
        r_status <= n_status;
        r_res    <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_seg_we) begin
            r_seg_mem[w_seg_wa] <= w_seg_wd;
        end
        r_seg_rd <= r_seg_mem[w_seg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_blk_we) begin
            r_blk_mem[r_slot] <= w_blk_wd;
        end
        r_blk_rd <= r_blk_mem[n_b];
    end

endmodule

FILE: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBLK = 16;
    localparam int NSEG = NBLK + 1;
    localparam int HDR = 16;
    localparam int SPLIT = 16;
    localparam int WD_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    ffa_pkg::t_in_item i_in_item = '0;
    logic empty;
    logic pop = 1'b0;
    ffa_pkg::t_out_item o_out_item;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [ffa_pkg::LEN_W-1:0] i_cfg_data = '0;

    first_fit_free_list_allocator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_in_item(i_in_item),
        .empty(empty), .pop(pop), .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // shadow copy of the allocator state
    int unsigned arena;
    int unsigned seg_st[NSEG];
    int unsigned seg_ln[NSEG];
    int seg_n;
    int unsigned blk_usr[NBLK];
    int unsigned blk_st[NBLK];
    int unsigned blk_ln[NBLK];
    bit blk_on[NBLK];
    int unsigned used_sum;

    ffa_pkg::t_out_item pending_results[$];
    int unsigned errors = 0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_alloc_ok = 0;
    int unsigned n_free_ok = 0;
    int unsigned n_err_status = 0;
    int unsigned idle_cycles = 0;
    bit src_idle = 1'b1;
    bit sink_idle = 1'b1;
    bit timed_out = 1'b0;

    function automatic void arena_reset(int unsigned sz);
        arena = sz;
        seg_n = 1;
        seg_st[0] = 0;
        seg_ln[0] = sz;
        foreach (blk_on[b]) blk_on[b] = 1'b0;
        used_sum = 0;
    endfunction

    function automatic void seg_drop(int i);
        for (int k = i; k + 1 < seg_n; k++) begin
            seg_st[k] = seg_st[k + 1];
            seg_ln[k] = seg_ln[k + 1];
        end
        seg_n--;
    endfunction

    function automatic bit seg_put(int unsigned st, int unsigned ln);
        int i;
        i = 0;
        if (seg_n >= NSEG) return 1'b0;
        while (i < seg_n && seg_st[i] <= st) i++;
        for (int k = seg_n; k > i; k--) begin
            seg_st[k] = seg_st[k - 1];
            seg_ln[k] = seg_ln[k - 1];
        end
        seg_st[i] = st;
        seg_ln[i] = ln;
        seg_n++;
        // merge with the following segment, then the preceding one
        if (i + 1 < seg_n && st + seg_ln[i] == seg_st[i + 1]) begin
            seg_ln[i] += seg_ln[i + 1];
            seg_drop(i + 1);
        end
        if (i > 0 && seg_st[i - 1] + seg_ln[i - 1] == seg_st[i]) begin
            seg_ln[i - 1] += seg_ln[i];
            seg_drop(i);
        end
        return 1'b1;
    endfunction

    // computes the allocator answer and updates the shadow state
    function automatic ffa_pkg::t_out_item alloc_predict(ffa_pkg::t_in_item it);
        ffa_pkg::t_out_item r;
        int unsigned sz, al, s, pad, need, rem, blen;
        int slot;
        r = '0;
        r.status = ffa_pkg::ST_NOFIT;
        if (it.cmd == ffa_pkg::CMD_ALLOC) begin
            sz = it.req_size;
            if (sz < 16) sz = 16;
            al = it.align;
            if (al == 0) al = 1;
            slot = -1;
            for (int b = NBLK - 1; b >= 0; b--) if (!blk_on[b]) slot = b;
            if (slot < 0) begin
                r.status = ffa_pkg::ST_FULL;
            end else begin
                for (int i = 0; i < seg_n; i++) begin
                    s = seg_st[i];
                    pad = HDR + (al - (s + HDR) % al) % al;
                    need = sz + pad;
                    if (seg_ln[i] >= need) begin
                        rem = seg_ln[i] - need;
                        blen = seg_ln[i];
                        if (rem > SPLIT) begin
                            seg_st[i] = s + need;
                            seg_ln[i] = rem;
                            blen = need;
                        end else begin
                            seg_drop(i);
                        end
                        blk_on[slot] = 1'b1;
                        blk_st[slot] = s;
                        blk_ln[slot] = blen;
                        blk_usr[slot] = s + pad;
                        used_sum += blen;
                        r.status = ffa_pkg::ST_OK;
                        r.result_addr = ffa_pkg::ADDR_W'(s + pad);
                        break;
                    end
                end
            end
        end else begin
            r.status = ffa_pkg::ST_BADADR;
            for (int b = 0; b < NBLK; b++) begin
                if (blk_on[b] && blk_usr[b] == it.block_addr) begin
                    if (seg_put(blk_st[b], blk_ln[b])) begin
                        blk_on[b] = 1'b0;
                        used_sum = used_sum >= blk_ln[b] ? used_sum - blk_ln[b] : 0;
                        r.status = ffa_pkg::ST_OK;
                    end
                    break;
                end
            end
        end
        r.used_bytes_out = ffa_pkg::LEN_W'(used_sum);
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch on result %0d: %s got %0d, expected %0d", n_checked, what, got,
                 want);
        errors++;
    endtask

    // result side: random stalls on pop, compare each beat with the oldest expectation
    initial begin
        int gap;
        ffa_pkg::t_out_item want;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $display("result beat with nothing expected");
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_item.status !== want.status)
                        report_mismatch("status", o_out_item.status, want.status);
                    if (o_out_item.result_addr !== want.result_addr)
                        report_mismatch("result_addr", o_out_item.result_addr,
                                        want.result_addr);
                    if (o_out_item.used_bytes_out !== want.used_bytes_out)
                        report_mismatch("used_bytes_out", o_out_item.used_bytes_out,
                                        want.used_bytes_out);
                end
                n_checked++;
                if (!sink_idle && $urandom_range(0, 5) == 0) begin
                    pop <= 1'b0;
                    gap = $urandom_range(1, 14);
                    repeat (gap) @(posedge i_clk);
                    pop <= 1'b1;
                end
            end else if (i_rst_n) begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog: cycles with no beat in either direction
    initial begin
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT) begin
                timed_out = 1'b1;
                $display("watchdog expired, %0d results outstanding", pending_results.size());
                $display("** first_fit_free_list_allocator: FAILED **");
                $finish;
            end
        end
    end

    // push stays high after a beat; it drops before an idle gap or in drain
    task automatic send_item(ffa_pkg::t_in_item it);
        int gap;
        if (!src_idle && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            gap = $urandom_range(1, 14);
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (full);
        pending_results.push_back(alloc_predict(it));
        n_sent++;
        if (it.cmd == ffa_pkg::CMD_ALLOC && pending_results[$].status == ffa_pkg::ST_OK)
            n_alloc_ok++;
        if (it.cmd == ffa_pkg::CMD_FREE && pending_results[$].status == ffa_pkg::ST_OK)
            n_free_ok++;
        if (pending_results[$].status != ffa_pkg::ST_OK) n_err_status++;
    endtask

    task automatic send_alloc(int unsigned sz, int unsigned al);
        ffa_pkg::t_in_item it;
        it = '0;
        it.cmd = ffa_pkg::CMD_ALLOC;
        it.req_size = ffa_pkg::SIZE_W'(sz);
        it.align = ffa_pkg::ALIGN_W'(al);
        it.block_addr = ffa_pkg::ADDR_W'($urandom);
        send_item(it);
    endtask

    task automatic send_free(int unsigned adr);
        ffa_pkg::t_in_item it;
        it = '0;
        it.cmd = ffa_pkg::CMD_FREE;
        it.req_size = ffa_pkg::SIZE_W'($urandom);
        it.align = ffa_pkg::ALIGN_W'($urandom);
        it.block_addr = ffa_pkg::ADDR_W'(adr);
        send_item(it);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // a late request can still be moving through the engine
        repeat (50) @(posedge i_clk);
    endtask

    // write the arena size; the shadow saturates it the same way
    task automatic set_arena(int unsigned raw);
        int unsigned v;
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= ffa_pkg::LEN_W'(raw);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        v = raw & 32'h1FFFF;
        if (v < 64) v = 64;
        if (v > 65536) v = 65536;
        arena_reset(v);
    endtask

    // a live user address, or noise
    function automatic int unsigned pick_live();
        int unsigned live[$];
        foreach (blk_on[b]) if (blk_on[b]) live.push_back(blk_usr[b]);
        if (live.size() == 0) return $urandom_range(0, 65535);
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    task automatic test_directed_extremes();
        send_alloc(0, 0);             // below minimum size, zero alignment
        send_alloc(17'h1FFFF, 8191);  // far too large
        send_alloc(65536, 1);         // does not fit with header
        send_alloc(100, 4096);        // largest power-of-two alignment
        send_alloc(40, 3);            // non-power-of-two alignment
        send_alloc(16, 1);
        send_free(0);                 // offset zero is never a block
        send_free(65535);
        send_free(pick_live());
        send_free(pick_live());
        send_free(pick_live());
        send_free(pick_live());
    endtask

    task automatic test_table_full();
        set_arena(65536);
        for (int k = 0; k < NBLK + 2; k++) send_alloc($urandom_range(0, 64), 1);
        // free random live blocks so merges can happen on either side
        send_free(pick_live());
        send_free(pick_live());
        send_free(pick_live());
    endtask

    task automatic test_small_arena();
        set_arena(0);   // saturates to the minimum
        send_alloc(16, 1);
        send_alloc(16, 1);
        send_free(pick_live());
        send_alloc(32, 1);
    endtask

    task automatic test_random(int n, int unsigned asz);
        int r;
        set_arena(asz);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (k > n - 60) begin
                src_idle = 1'b1;
                sink_idle = 1'b1;
            end
            if (r < 45) begin
                case ($urandom_range(0, 3))
                    0: send_alloc($urandom_range(0, 256), 1 << $urandom_range(0, 6));
                    1: send_alloc($urandom_range(0, asz / 4), $urandom_range(0, 8191));
                    2: send_alloc($urandom_range(0, 17'h1FFFF), 1 << $urandom_range(0, 12));
                    default: send_alloc($urandom_range(0, 2048), $urandom_range(1, 100));
                endcase
            end else if (r < 90) begin
                send_free(pick_live());
            end else begin
                send_free($urandom_range(0, 65535));
            end
        end
        src_idle = 1'b0;
        sink_idle = 1'b0;
    endtask

    initial begin
        arena_reset(65536);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        src_idle = 1'b0;
        sink_idle = 1'b0;
        test_table_full();
        test_small_arena();
        test_random(130, 65536);
        test_random(100, 1000);
        test_random(40, 17'h1FFFF);  // above range, saturates to the maximum
        test_random(130, 4096);
        drain();
        $display("sent %0d requests, checked %0d results", n_sent, n_checked);
        $display("%0d good allocates, %0d good frees, %0d error answers", n_alloc_ok,
                 n_free_ok, n_err_status);
        if (errors == 0 && !timed_out)
            $display("** first_fit_free_list_allocator: PASSED **");
        else
            $display("** first_fit_free_list_allocator: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
rtl/ffa_pkg.sv
rtl/ffa_fifo.sv
rtl/ffa_front.sv
rtl/ffa_back.sv
rtl/first_fit_free_list_allocator.sv
bench/tb_top.sv
